// File: rtl/i2c_eeprom_page_sequencer_unit_macros.svh
// assertion helpers for the page sequencer
// the enclosing module provides clk_i and rst_ni
`ifndef I2C_EEPROM_PAGE_SEQUENCER_UNIT_MACROS_SVH
`define I2C_EEPROM_PAGE_SEQUENCER_UNIT_MACROS_SVH

// property checked on every rising clock edge, off while reset is active
`define I2CPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication, off while reset is active
`define I2CPS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/i2cps_pkg.sv
// ----------------------------------------------------------------------------
// i2cps_pkg
// types and constants shared by the i2c eeprom page sequencer
// ----------------------------------------------------------------------------
package i2cps_pkg;

  localparam int unsigned PageBytes = 32;
  localparam int unsigned PageBits  = $clog2(PageBytes);
  localparam logic [7:0]  DevReset  = 8'd160;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QIdxW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    ActStart = 3'd0,
    ActSend  = 3'd1,
    ActRack  = 3'd2,
    ActRnack = 3'd3,
    ActStop  = 3'd4,
    ActWait  = 3'd5
  } act_e;

  // primitive slots of one request, emitted in this order when enabled
  localparam int unsigned NumSlots = 10;
  localparam int unsigned SlotW    = $clog2(NumSlots);
  localparam logic [SlotW-1:0] SlotPreStop = 4'd0;
  localparam logic [SlotW-1:0] SlotStart   = 4'd1;
  localparam logic [SlotW-1:0] SlotDev     = 4'd2;
  localparam logic [SlotW-1:0] SlotAddrHi  = 4'd3;
  localparam logic [SlotW-1:0] SlotAddrLo  = 4'd4;
  localparam logic [SlotW-1:0] SlotRestart = 4'd5;
  localparam logic [SlotW-1:0] SlotDevRd   = 4'd6;
  localparam logic [SlotW-1:0] SlotMain    = 4'd7;
  localparam logic [SlotW-1:0] SlotStop    = 4'd8;
  localparam logic [SlotW-1:0] SlotWait    = 4'd9;

  typedef struct packed {
    logic        mode;
    logic [15:0] start_address;
    logic [7:0]  data_byte;
    logic        first_of_run;
    logic        last_of_run;
  } item_t;

  typedef struct packed {
    act_e       bus_action;
    logic [7:0] byte_value;
    logic       last;
  } result_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        pre_stop;
    logic        open;
    logic        rd;
    logic        close;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  dev;
  } cmd_t;

endpackage

// File: rtl/i2c_eeprom_page_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_page_sequencer_unit
// byte-level sequencer for a two-address-byte i2c eeprom
// ----------------------------------------------------------------------------
// Input side is a queue: drive in_item_i and raise push while full is low;
// each request carries one data byte of a read or write run. Result side is
// a queue too: while empty is low out_item_o holds the oldest bus primitive
// (start, send byte, read ack/nack, stop, wait write cycle), taken by pop.
// last marks the final primitive caused by one request.
// The device write byte is written over cfg_valid/cfg_data_i; cfg_ready is
// always high. Write it only while the block is idle.
// With the back end free, the first primitive of a request passes through the
// queue and then the result register before it shows on the result ports. A
// request gives 1 to 9 primitives, delivered at one per cycle while pop keeps
// up; the front accepts one request per cycle, while full is low, into a
// two-entry queue.
// When pop stays low the result register holds, the back end stops, and
// once the queue fills full rises. Reset clears the run state, the queue
// and the result register, and sets the device write byte to 160.
// ----------------------------------------------------------------------------
module i2c_eeprom_page_sequencer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  i2cps_pkg::item_t   in_item_i,
  output logic               empty,
  input  logic               pop,
  output i2cps_pkg::result_t out_item_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data_i
);
  import i2cps_pkg::*;

  cmd_t cmd, head;
  logic accept, head_valid, head_empty, head_pop;

  assign cfg_ready  = 1'b1;
  assign accept     = push && !full;
  assign head_valid = !head_empty;

  i2cps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .cfg_we_i   (cfg_valid && cfg_ready),
    .cfg_data_i (cfg_data_i),
    .cmd_o      (cmd)
  );

  i2cps_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept),
    .wr_cmd_i (cmd),
    .full_o   (full),
    .rd_i     (head_pop),
    .rd_cmd_o (head),
    .empty_o  (head_empty)
  );

  i2cps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .pop          (pop),
    .empty        (empty),
    .out_o        (out_item_o)
  );

endmodule

// File: rtl/i2cps_front.sv
// ----------------------------------------------------------------------------
// i2cps_front
// run tracking and classification of incoming requests
// ----------------------------------------------------------------------------
module i2cps_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  i2cps_pkg::item_t item_i,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_data_i,
  output i2cps_pkg::cmd_t  cmd_o
);
  import i2cps_pkg::*;

  logic [7:0]  dev_q, dev_d;
  logic [15:0] addr_q, addr_d;
  logic        open_q, open_d;
  logic        rd_q, rd_d;
  logic [15:0] addr_use, addr_nxt;
  logic        pre_stop, close;

  always_comb begin
    pre_stop = open_q && (item_i.first_of_run || (rd_q != item_i.mode));
    addr_use = item_i.first_of_run ? item_i.start_address : addr_q;
    addr_nxt = addr_use + 16'd1;
    if (item_i.mode) begin
      close = item_i.last_of_run;
    end else begin
      close = item_i.last_of_run || (addr_nxt[PageBits-1:0] == '0);
    end

    cmd_o.pre_stop = pre_stop;
    cmd_o.open     = !open_q || pre_stop;
    cmd_o.rd       = item_i.mode;
    cmd_o.close    = close;
    cmd_o.addr     = addr_use;
    cmd_o.data     = item_i.data_byte;
    cmd_o.dev      = dev_q;

    dev_d  = cfg_we_i ? cfg_data_i : dev_q;
    addr_d = accept_i ? addr_nxt : addr_q;
    open_d = accept_i ? !close : open_q;
    rd_d   = accept_i ? item_i.mode : rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q  <= DevReset;
      addr_q <= '0;
      open_q <= 1'b0;
      rd_q   <= 1'b0;
    end else begin
      dev_q  <= dev_d;
      addr_q <= addr_d;
      open_q <= open_d;
      rd_q   <= rd_d;
    end
  end

endmodule

// File: rtl/i2cps_queue.sv
// ----------------------------------------------------------------------------
// i2cps_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
module i2cps_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  i2cps_pkg::cmd_t wr_cmd_i,
  output logic            full_o,
  input  logic            rd_i,
  output i2cps_pkg::cmd_t rd_cmd_o,
  output logic            empty_o
);
  import i2cps_pkg::*;

  cmd_t             buf_q [QDepth];
  logic [QIdxW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  always_comb begin
    full_o   = (cnt_q == QCntW'(QDepth));
    empty_o  = (cnt_q == '0);
    do_wr    = wr_i && !full_o;
    do_rd    = rd_i && !empty_o;
    rd_cmd_o = buf_q[rptr_q];
    wptr_d   = do_wr ? ((wptr_q == QIdxW'(QDepth - 1)) ? '0 : wptr_q + 1'b1) : wptr_q;
    rptr_d   = do_rd ? ((rptr_q == QIdxW'(QDepth - 1)) ? '0 : rptr_q + 1'b1) : rptr_q;
    cnt_d    = cnt_q + QCntW'(do_wr) - QCntW'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      buf_q[wptr_q] <= wr_cmd_i;
    end
  end

endmodule

// File: rtl/i2cps_back.sv
// ----------------------------------------------------------------------------
// i2cps_back
// expands each request into bus primitives, one per cycle unless pop stalls the result
// ----------------------------------------------------------------------------
module i2cps_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  i2cps_pkg::cmd_t    head_i,
  output logic               head_pop_o,
  input  logic               pop,
  output logic               empty,
  output i2cps_pkg::result_t out_o
);
  import i2cps_pkg::*;

  logic [NumSlots-1:0] en, cur, low, rem_q, rem_d;
  logic                loaded_q, loaded_d;
  logic                out_valid_q, out_valid_d;
  result_t             out_q, res;
  logic [SlotW-1:0]    slot;
  logic                adv;

  always_comb begin
    en = '0;
    en[SlotPreStop] = head_i.pre_stop;
    en[SlotStart]   = head_i.open;
    en[SlotDev]     = head_i.open;
    en[SlotAddrHi]  = head_i.open;
    en[SlotAddrLo]  = head_i.open;
    en[SlotRestart] = head_i.open && head_i.rd;
    en[SlotDevRd]   = head_i.open && head_i.rd;
    en[SlotMain]    = 1'b1;
    en[SlotStop]    = head_i.close;
    en[SlotWait]    = head_i.close && !head_i.rd;

    cur  = loaded_q ? rem_q : en;
    low  = cur & (~cur + 1'b1);
    slot = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (low[i]) begin
        slot = SlotW'(i);
      end
    end

    res.byte_value = '0;
    res.last       = ((cur & ~low) == '0);
    case (slot)
      SlotPreStop: res.bus_action = ActStop;
      SlotStart:   res.bus_action = ActStart;
      SlotDev: begin
        res.bus_action = ActSend;
        res.byte_value = head_i.dev;
      end
      SlotAddrHi: begin
        res.bus_action = ActSend;
        res.byte_value = head_i.addr[15:8];
      end
      SlotAddrLo: begin
        res.bus_action = ActSend;
        res.byte_value = head_i.addr[7:0];
      end
      SlotRestart: res.bus_action = ActStart;
      SlotDevRd: begin
        res.bus_action = ActSend;
        res.byte_value = head_i.dev + 8'd1;
      end
      SlotMain: begin
        if (head_i.rd) begin
          res.bus_action = head_i.close ? ActRnack : ActRack;
        end else begin
          res.bus_action = ActSend;
          res.byte_value = head_i.data;
        end
      end
      SlotStop:    res.bus_action = ActStop;
      SlotWait:    res.bus_action = ActWait;
      default:     res.bus_action = ActStop;
    endcase

    adv         = head_valid_i && (!out_valid_q || pop);
    head_pop_o  = adv && res.last;
    rem_d       = adv ? (cur & ~low) : rem_q;
    loaded_d    = adv ? !res.last : loaded_q;
    out_valid_d = adv || (out_valid_q && !pop);
    empty       = !out_valid_q;
    out_o       = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      loaded_q    <= loaded_d;
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

endmodule

// File: rtl/i2cps_chk.sv
// ----------------------------------------------------------------------------
// i2cps_chk
// port-level checks for the page sequencer
// ----------------------------------------------------------------------------
`include "i2c_eeprom_page_sequencer_unit_macros.svh"

module i2cps_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input i2cps_pkg::result_t out_item_o
);
  import i2cps_pkg::*;

  logic       shown;
  act_e       act;
  logic [7:0] val;
  logic       lst;

  assign shown = !empty;
  assign act   = out_item_o.bus_action;
  assign val   = out_item_o.byte_value;
  assign lst   = out_item_o.last;

  `I2CPS_ASSERT(a_out_hold, (shown && !pop) |=> (shown && $stable(out_item_o)), "result not held")
  `I2CPS_IMPLY(a_byte_zero, shown && act != ActSend, val == 8'd0, "byte set on non-send")
  `I2CPS_IMPLY(a_wait_last, shown && act == ActWait, lst, "wait not last of request")
  `I2CPS_IMPLY(a_nack_stop, shown && act == ActRnack, !lst, "nack not followed by stop")
  `I2CPS_IMPLY(a_full_busy, full, shown, "queue full with no result")

endmodule

bind i2c_eeprom_page_sequencer_unit i2cps_chk u_chk (.*);
